FILE: rtl/dual_tap_feedback_delay_assert.svh
// Assertion macros shared by the delay block's RTL files.
// Each macro expects signals named clk and rst_n in the including module.
`ifndef DUAL_TAP_FEEDBACK_DELAY_ASSERT_SVH
`define DUAL_TAP_FEEDBACK_DELAY_ASSERT_SVH
`ifndef SYNTH
`define DTFD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dtfd implication check failed");
`define DTFD_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dtfd next-cycle check failed");
`define DTFD_ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("dtfd forbidden condition seen");
`else
`define DTFD_ASSERT_IMP(label, ante, cons)
`define DTFD_ASSERT_NXT(label, ante, cons)
`define DTFD_ASSERT_NEVER(label, cond)
`endif
`endif

FILE: rtl/dtfd_pkg.sv
// Package for the dual-tap feedback delay: fixed field widths, register
// codes, reset values and the structs passed between its modules.
package dtfd_pkg;

  localparam int NUM_CH     = 2;
  localparam int DELAY_W    = 24;
  localparam int FRAC_W     = 8;
  localparam int FB_W       = 15;
  localparam int MIX_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [FB_W-1:0]    FB_MAX      = 15'd31129;
  localparam logic [MIX_W-1:0]   MIX_ONE     = 16'd32768;
  localparam logic [DELAY_W-1:0] DELAY_A_RST = 24'd3072000;
  localparam logic [DELAY_W-1:0] DELAY_B_RST = 24'd4608000;
  localparam logic [FB_W-1:0]    FB_RST      = 15'd9830;
  localparam logic [MIX_W-1:0]   MIX_RST     = 16'd11469;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DELAY_A  = 2'd0,
    REG_DELAY_B  = 2'd1,
    REG_FEEDBACK = 2'd2,
    REG_WET_MIX  = 2'd3
  } cfg_reg_t;

  // Per-frame tap control worked out by the front end
  typedef struct packed {
    logic [FRAC_W-1:0] frac_a;
    logic [FRAC_W-1:0] frac_b;
    logic              vld_a0;
    logic              vld_a1;
    logic              vld_b0;
    logic              vld_b1;
    logic [FB_W-1:0]   fb;
    logic [MIX_W-1:0]  mix;
  } tap_ctl_t;

  localparam int TAP_CTL_W = $bits(tap_ctl_t);

  typedef struct packed {
    logic empty;
    logic full;
    logic afull;
  } fifo_stat_t;

endpackage

FILE: rtl/dtfd_fifo.sv
// Small register FIFO used for the job queue and the result queue.
// Depends on dtfd_pkg (status struct) and the assertion macro header.
`include "dual_tap_feedback_delay_assert.svh"
module dtfd_fifo #(
  parameter int DEPTH = 2,
  parameter int WIDTH = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push_i,
  input  logic [WIDTH-1:0]     din_i,
  input  logic                 pop_i,
  output logic [WIDTH-1:0]     dout_o,
  output dtfd_pkg::fifo_stat_t stat_o
);
  import dtfd_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             wr_en, rd_en;

  assign stat_o.empty = (cnt_r == '0);
  assign stat_o.full  = (cnt_r == CNT_W'(DEPTH));
  assign stat_o.afull = (cnt_r >= CNT_W'(DEPTH - 1));

  assign wr_en  = push_i && !stat_o.full;
  assign rd_en  = pop_i && !stat_o.empty;
  assign dout_o = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_en ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = rd_en ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (rd_en && !wr_en) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= din_i;
    end
  end

  `DTFD_ASSERT_NEVER(a_fifo_cnt_bound, cnt_r > CNT_W'(DEPTH))
  `DTFD_ASSERT_NXT(a_fifo_push_fills, wr_en && !rd_en, !stat_o.empty)

endmodule

FILE: rtl/dtfd_line_ram.sv
// One delay line: single write port, two registered read ports.
// No package dependency.
module dtfd_line_ram #(
  parameter int DEPTH = 65536,
  parameter int AW    = 16,
  parameter int W     = 24
) (
  input  logic          clk,
  input  logic          re_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [W-1:0]  wdata_i,
  input  logic [AW-1:0] raddr0_i,
  input  logic [AW-1:0] raddr1_i,
  output logic [W-1:0]  rdata0_o,
  output logic [W-1:0]  rdata1_o
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk) begin
    if (re_i) begin
      rdata0_o <= mem[raddr0_i];
      rdata1_o <= mem[raddr1_i];
    end
  end

endmodule

FILE: rtl/dtfd_front.sv
// Front end: config registers, input acceptance, write pointer and tap
// address / fill-validity classification. Depends on dtfd_pkg.
module dtfd_front #(
  parameter int AW = 16,
  parameter int SB = 24
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_valid_i,
  input  logic [dtfd_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [dtfd_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  input  logic                                  push_i,
  input  logic [SB-1:0]                         sample_left_i,
  input  logic [SB-1:0]                         sample_right_i,
  input  dtfd_pkg::fifo_stat_t                  job_stat_i,
  output logic                                  job_push_o,
  output logic [dtfd_pkg::NUM_CH-1:0][SB-1:0]   job_x_o,
  output logic [AW-1:0]                         job_wp_o,
  output logic [AW-1:0]                         job_ia0_o,
  output logic [AW-1:0]                         job_ia1_o,
  output logic [AW-1:0]                         job_ib0_o,
  output logic [AW-1:0]                         job_ib1_o,
  output dtfd_pkg::tap_ctl_t                    job_ctl_o
);
  import dtfd_pkg::*;

  localparam int PW = AW + FRAC_W;
  localparam int EW = (PW > DELAY_W) ? PW : DELAY_W;

  logic [DELAY_W-1:0] delay_a_r, delay_a_nxt;
  logic [DELAY_W-1:0] delay_b_r, delay_b_nxt;
  logic [FB_W-1:0]    fb_r, fb_nxt;
  logic [MIX_W-1:0]   mix_r, mix_nxt;
  logic [AW-1:0]      wp_r, wp_nxt;
  logic               wrap_r, wrap_nxt;

  logic [EW-1:0]      pos_a_full, pos_b_full;
  logic [PW-1:0]      pos_a, pos_b;
  logic               accept;

  always_comb begin
    delay_a_nxt = delay_a_r;
    delay_b_nxt = delay_b_r;
    fb_nxt      = fb_r;
    mix_nxt     = mix_r;
    if (cfg_valid_i) begin
      unique case (cfg_reg_t'(cfg_index_i))
        REG_DELAY_A:  delay_a_nxt = cfg_data_i[DELAY_W-1:0];
        REG_DELAY_B:  delay_b_nxt = cfg_data_i[DELAY_W-1:0];
        REG_FEEDBACK: fb_nxt      = cfg_data_i[FB_W-1:0];
        REG_WET_MIX:  mix_nxt     = cfg_data_i[MIX_W-1:0];
        default: ;
      endcase
    end
  end

  assign accept     = push_i && !job_stat_i.full;
  assign job_push_o = accept;

  // Write pointer moves once per frame; wrap flag marks every entry written
  always_comb begin
    wp_nxt   = wp_r;
    wrap_nxt = wrap_r;
    if (accept) begin
      wp_nxt   = wp_r + AW'(1);
      wrap_nxt = wrap_r | (wp_r == '1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_a_r <= DELAY_A_RST;
      delay_b_r <= DELAY_B_RST;
      fb_r      <= FB_RST;
      mix_r     <= MIX_RST;
      wp_r      <= '0;
      wrap_r    <= 1'b0;
    end else begin
      delay_a_r <= delay_a_nxt;
      delay_b_r <= delay_b_nxt;
      fb_r      <= fb_nxt;
      mix_r     <= mix_nxt;
      wp_r      <= wp_nxt;
      wrap_r    <= wrap_nxt;
    end
  end

  // Read position in 16.8 form, taken modulo the line length
  assign pos_a_full = EW'({wp_r, {FRAC_W{1'b0}}}) - EW'(delay_a_r);
  assign pos_b_full = EW'({wp_r, {FRAC_W{1'b0}}}) - EW'(delay_b_r);
  assign pos_a      = pos_a_full[PW-1:0];
  assign pos_b      = pos_b_full[PW-1:0];

  assign job_x_o[0] = sample_left_i;
  assign job_x_o[1] = sample_right_i;
  assign job_wp_o   = wp_r;
  assign job_ia0_o  = pos_a[PW-1:FRAC_W];
  assign job_ia1_o  = pos_a[PW-1:FRAC_W] + AW'(1);
  assign job_ib0_o  = pos_b[PW-1:FRAC_W];
  assign job_ib1_o  = pos_b[PW-1:FRAC_W] + AW'(1);

  // Entries not yet written since reset read as zero
  always_comb begin
    job_ctl_o.frac_a = pos_a[FRAC_W-1:0];
    job_ctl_o.frac_b = pos_b[FRAC_W-1:0];
    job_ctl_o.vld_a0 = wrap_r || (job_ia0_o < wp_r);
    job_ctl_o.vld_a1 = wrap_r || (job_ia1_o < wp_r);
    job_ctl_o.vld_b0 = wrap_r || (job_ib0_o < wp_r);
    job_ctl_o.vld_b1 = wrap_r || (job_ib1_o < wp_r);
    job_ctl_o.fb     = (fb_r > FB_MAX) ? FB_MAX : fb_r;
    job_ctl_o.mix    = (mix_r > MIX_ONE) ? MIX_ONE : mix_r;
  end

endmodule

FILE: rtl/dtfd_back.sv
// Back end: per-frame sequencer, delay line memories, interpolation,
// feedback write-back and wet/dry mix. Depends on dtfd_pkg, dtfd_line_ram.
`include "dual_tap_feedback_delay_assert.svh"
module dtfd_back #(
  parameter int LINE_DEPTH = 65536,
  parameter int AW         = $clog2(LINE_DEPTH),
  parameter int SB         = 24
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  dtfd_pkg::fifo_stat_t                job_stat_i,
  input  logic [dtfd_pkg::NUM_CH-1:0][SB-1:0] job_x_i,
  input  logic [AW-1:0]                       job_wp_i,
  input  logic [AW-1:0]                       job_ia0_i,
  input  logic [AW-1:0]                       job_ia1_i,
  input  logic [AW-1:0]                       job_ib0_i,
  input  logic [AW-1:0]                       job_ib1_i,
  input  dtfd_pkg::tap_ctl_t                  job_ctl_i,
  output logic                                job_pop_o,
  input  dtfd_pkg::fifo_stat_t                out_stat_i,
  output logic                                out_push_o,
  output logic [dtfd_pkg::NUM_CH-1:0][SB-1:0] out_y_o
);
  import dtfd_pkg::*;

  localparam int FB_SHIFT  = 15;
  localparam int OUT_SHIFT = 16;
  localparam int IP_W      = SB + FRAC_W + 2;
  localparam int FBP_W     = SB + 16;
  localparam int DRY_W     = SB + 17;
  localparam int WET_W     = SB + 18;
  localparam int ACC_W     = SB + 19;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_RD     = 5'b00010,
    ST_INTERP = 5'b00100,
    ST_MUL    = 5'b01000,
    ST_WB     = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   start;

  logic [NUM_CH-1:0][SB-1:0] x_r, x_nxt;
  logic [AW-1:0]             wp_r, wp_nxt;
  logic [AW-1:0]             ia0_r, ia0_nxt, ia1_r, ia1_nxt;
  logic [AW-1:0]             ib0_r, ib0_nxt, ib1_r, ib1_nxt;
  tap_ctl_t                  ctl_r, ctl_nxt;
  logic [SB-1:0]             y_w [NUM_CH];

  function automatic logic [SB-1:0] sat(input logic signed [SB+2:0] v);
    logic [SB-1:0] res;
    priority if ((v[SB+2:SB-1] == '0) || (v[SB+2:SB-1] == '1)) begin
      res = v[SB-1:0];
    end else if (v[SB+2]) begin
      res = {1'b1, {(SB-1){1'b0}}};
    end else begin
      res = {1'b0, {(SB-1){1'b1}}};
    end
    return res;
  endfunction

  // floor(s0 + f*(s1-s0)/256); result lies between s0 and s1
  function automatic logic signed [SB-1:0] interp(input logic signed [SB-1:0] s0,
                                                  input logic signed [SB-1:0] s1,
                                                  input logic [FRAC_W-1:0] f);
    logic signed [SB:0]     d;
    logic signed [IP_W-1:0] p;
    logic signed [IP_W-1:0] acc;
    d   = (SB+1)'(s1) - (SB+1)'(s0);
    p   = IP_W'($signed({1'b0, f})) * IP_W'(d);
    acc = (IP_W'(s0) <<< FRAC_W) + p;
    return acc[SB+FRAC_W-1:FRAC_W];
  endfunction

  function automatic logic [SB-1:0] fb_write(input logic signed [SB-1:0] x,
                                             input logic signed [FBP_W-1:0] p);
    logic signed [FBP_W-1:0] rp;
    logic signed [SB+2:0]    w;
    rp = p + (FBP_W'(1) <<< (FB_SHIFT - 1));
    w  = (SB+3)'(x) + (SB+3)'($signed(rp[FBP_W-1:FB_SHIFT]));
    return sat(w);
  endfunction

  function automatic logic [SB-1:0] mix_out(input logic signed [DRY_W-1:0] dry,
                                            input logic signed [WET_W-1:0] wet);
    logic signed [ACC_W-1:0] acc;
    acc = (ACC_W'(dry) <<< 1) + ACC_W'(wet) + (ACC_W'(1) <<< (OUT_SHIFT - 1));
    return sat(acc[ACC_W-1:OUT_SHIFT]);
  endfunction

  // Next frame may start straight from write-back when the result queue
  // still has a slot after this frame's result goes in
  always_comb begin
    start = 1'b0;
    if (!job_stat_i.empty) begin
      if (state_r == ST_IDLE) begin
        start = !out_stat_i.full;
      end else if (state_r == ST_WB) begin
        start = !out_stat_i.afull;
      end
    end
  end

  always_comb begin
    unique case (state_r)
      ST_IDLE:   state_nxt = start ? ST_RD : ST_IDLE;
      ST_RD:     state_nxt = ST_INTERP;
      ST_INTERP: state_nxt = ST_MUL;
      ST_MUL:    state_nxt = ST_WB;
      ST_WB:     state_nxt = start ? ST_RD : ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign job_pop_o  = start;
  assign out_push_o = (state_r == ST_WB);

  always_comb begin
    x_nxt   = x_r;
    wp_nxt  = wp_r;
    ia0_nxt = ia0_r;
    ia1_nxt = ia1_r;
    ib0_nxt = ib0_r;
    ib1_nxt = ib1_r;
    ctl_nxt = ctl_r;
    if (start) begin
      x_nxt   = job_x_i;
      wp_nxt  = job_wp_i;
      ia0_nxt = job_ia0_i;
      ia1_nxt = job_ia1_i;
      ib0_nxt = job_ib0_i;
      ib1_nxt = job_ib1_i;
      ctl_nxt = job_ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    x_r   <= x_nxt;
    wp_r  <= wp_nxt;
    ia0_r <= ia0_nxt;
    ia1_r <= ia1_nxt;
    ib0_r <= ib0_nxt;
    ib1_r <= ib1_nxt;
    ctl_r <= ctl_nxt;
  end

  for (genvar c = 0; c < NUM_CH; c++) begin : g_ch
    logic [SB-1:0]           a_rd0, a_rd1, b_rd0, b_rd1;
    logic [SB-1:0]           a_wdata, b_wdata;
    logic signed [SB-1:0]    a_s0, a_s1, b_s0, b_s1;
    logic signed [SB-1:0]    dly_a_r, dly_a_nxt, dly_b_r, dly_b_nxt;
    logic signed [SB:0]      tap_sum;
    logic signed [FBP_W-1:0] fbp_a_r, fbp_a_nxt, fbp_b_r, fbp_b_nxt;
    logic signed [DRY_W-1:0] dry_r, dry_nxt;
    logic signed [WET_W-1:0] wet_r, wet_nxt;

    dtfd_line_ram #(.DEPTH(LINE_DEPTH), .AW(AW), .W(SB)) u_line_a (
      .clk      (clk),
      .re_i     (state_r == ST_RD),
      .we_i     (state_r == ST_WB),
      .waddr_i  (wp_r),
      .wdata_i  (a_wdata),
      .raddr0_i (ia0_r),
      .raddr1_i (ia1_r),
      .rdata0_o (a_rd0),
      .rdata1_o (a_rd1)
    );

    dtfd_line_ram #(.DEPTH(LINE_DEPTH), .AW(AW), .W(SB)) u_line_b (
      .clk      (clk),
      .re_i     (state_r == ST_RD),
      .we_i     (state_r == ST_WB),
      .waddr_i  (wp_r),
      .wdata_i  (b_wdata),
      .raddr0_i (ib0_r),
      .raddr1_i (ib1_r),
      .rdata0_o (b_rd0),
      .rdata1_o (b_rd1)
    );

    assign a_s0 = ctl_r.vld_a0 ? $signed(a_rd0) : '0;
    assign a_s1 = ctl_r.vld_a1 ? $signed(a_rd1) : '0;
    assign b_s0 = ctl_r.vld_b0 ? $signed(b_rd0) : '0;
    assign b_s1 = ctl_r.vld_b1 ? $signed(b_rd1) : '0;

    assign dly_a_nxt = (state_r == ST_INTERP) ? interp(a_s0, a_s1, ctl_r.frac_a) : dly_a_r;
    assign dly_b_nxt = (state_r == ST_INTERP) ? interp(b_s0, b_s1, ctl_r.frac_b) : dly_b_r;

    assign tap_sum = (SB+1)'(dly_a_r) + (SB+1)'(dly_b_r);

    always_comb begin
      fbp_a_nxt = fbp_a_r;
      fbp_b_nxt = fbp_b_r;
      dry_nxt   = dry_r;
      wet_nxt   = wet_r;
      if (state_r == ST_MUL) begin
        fbp_a_nxt = FBP_W'($signed({1'b0, ctl_r.fb})) * FBP_W'(dly_a_r);
        fbp_b_nxt = FBP_W'($signed({1'b0, ctl_r.fb})) * FBP_W'(dly_b_r);
        dry_nxt   = DRY_W'($signed({1'b0, MIX_ONE - ctl_r.mix})) * DRY_W'($signed(x_r[c]));
        wet_nxt   = WET_W'($signed({1'b0, ctl_r.mix})) * WET_W'(tap_sum);
      end
    end

    always_ff @(posedge clk) begin
      dly_a_r <= dly_a_nxt;
      dly_b_r <= dly_b_nxt;
      fbp_a_r <= fbp_a_nxt;
      fbp_b_r <= fbp_b_nxt;
      dry_r   <= dry_nxt;
      wet_r   <= wet_nxt;
    end

    assign a_wdata = fb_write($signed(x_r[c]), fbp_a_r);
    assign b_wdata = fb_write($signed(x_r[c]), fbp_b_r);
    assign y_w[c]  = mix_out(dry_r, wet_r);
  end

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      out_y_o[c] = y_w[c];
    end
  end

  `DTFD_ASSERT_IMP(a_pop_has_job, job_pop_o, !job_stat_i.empty)
  `DTFD_ASSERT_IMP(a_push_has_room, out_push_o, !out_stat_i.full)
  `DTFD_ASSERT_IMP(a_read_after_pop, state_r == ST_RD, $past(job_pop_o))

endmodule

FILE: rtl/dual_tap_feedback_delay.sv
// Top level of the dual-tap stereo feedback delay.
// Depends on dtfd_pkg, dtfd_front, dtfd_fifo, dtfd_back.
//
//   channel  signals                                  transaction when
//   in       in_push/in_full, in_sample_left/right    in_push && !in_full
//   out      out_pop/out_empty, out_left/out_right    out_pop && !out_empty
//   cfg      cfg_valid/cfg_ready, cfg_index/cfg_data  cfg_valid && cfg_ready
//
// A frame passes through the back-end sequencer states in order (read both
// line ports, interpolate, multiply, write back); the next frame may start
// straight from write-back if a job waits and the result queue keeps a slot free.
// Reset is immediate: a fill flag makes never-written line entries read zero.
// in_full follows a 2-deep job queue; a full 2-deep result queue stalls the back end.
module dual_tap_feedback_delay #(
  parameter int LINE_DEPTH  = 65536,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_push,
  output logic                                 in_full,
  input  logic signed [SAMPLE_BITS-1:0]        in_sample_left,
  input  logic signed [SAMPLE_BITS-1:0]        in_sample_right,
  output logic                                 out_empty,
  input  logic                                 out_pop,
  output logic signed [SAMPLE_BITS-1:0]        out_left,
  output logic signed [SAMPLE_BITS-1:0]        out_right,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [dtfd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dtfd_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import dtfd_pkg::*;

  localparam int AW         = $clog2(LINE_DEPTH);
  localparam int SB         = SAMPLE_BITS;
  localparam int QDEPTH     = 2;
  localparam int JOB_W      = TAP_CTL_W + 5 * AW + NUM_CH * SB;
  localparam int OUT_W      = NUM_CH * SB;

  fifo_stat_t                job_stat, out_stat;
  logic                      job_push, job_pop, out_push;
  logic [JOB_W-1:0]          job_din, job_dout;
  logic [OUT_W-1:0]          out_dout;

  logic [NUM_CH-1:0][SB-1:0] f_x, b_x, y;
  logic [AW-1:0]             f_wp, f_ia0, f_ia1, f_ib0, f_ib1;
  logic [AW-1:0]             b_wp, b_ia0, b_ia1, b_ib0, b_ib1;
  tap_ctl_t                  f_ctl, b_ctl;

  assign cfg_ready = 1'b1;
  assign in_full   = job_stat.full;
  assign out_empty = out_stat.empty;

  dtfd_front #(.AW(AW), .SB(SB)) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .push_i         (in_push),
    .sample_left_i  (in_sample_left),
    .sample_right_i (in_sample_right),
    .job_stat_i     (job_stat),
    .job_push_o     (job_push),
    .job_x_o        (f_x),
    .job_wp_o       (f_wp),
    .job_ia0_o      (f_ia0),
    .job_ia1_o      (f_ia1),
    .job_ib0_o      (f_ib0),
    .job_ib1_o      (f_ib1),
    .job_ctl_o      (f_ctl)
  );

  assign job_din = {f_ctl, f_wp, f_ia0, f_ia1, f_ib0, f_ib1, f_x};
  assign {b_ctl, b_wp, b_ia0, b_ia1, b_ib0, b_ib1, b_x} = job_dout;

  dtfd_fifo #(.DEPTH(QDEPTH), .WIDTH(JOB_W)) u_job_q (
    .clk    (clk),
    .rst_n  (rst_n),
    .push_i (job_push),
    .din_i  (job_din),
    .pop_i  (job_pop),
    .dout_o (job_dout),
    .stat_o (job_stat)
  );

  dtfd_back #(.LINE_DEPTH(LINE_DEPTH), .AW(AW), .SB(SB)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .job_stat_i (job_stat),
    .job_x_i    (b_x),
    .job_wp_i   (b_wp),
    .job_ia0_i  (b_ia0),
    .job_ia1_i  (b_ia1),
    .job_ib0_i  (b_ib0),
    .job_ib1_i  (b_ib1),
    .job_ctl_i  (b_ctl),
    .job_pop_o  (job_pop),
    .out_stat_i (out_stat),
    .out_push_o (out_push),
    .out_y_o    (y)
  );

  dtfd_fifo #(.DEPTH(QDEPTH), .WIDTH(OUT_W)) u_out_q (
    .clk    (clk),
    .rst_n  (rst_n),
    .push_i (out_push),
    .din_i  (y),
    .pop_i  (out_pop),
    .dout_o (out_dout),
    .stat_o (out_stat)
  );

  assign out_left  = out_dout[SB-1:0];
  assign out_right = out_dout[2*SB-1:SB];

endmodule
